FILE: src/tla_pkg.sv
// ----------------------------------------------------------------------------
// tla_pkg
// shared types and constants for the thermocouple linearizer and averager
// ----------------------------------------------------------------------------
package tla_pkg;

  localparam int SAMPLE_W = 12;
  localparam int AMB_W    = 8;
  localparam int TEMP_W   = 16;
  localparam int SUM_W    = 22;
  localparam int DIVD_W   = 19;
  localparam int DIVS_W   = 12;
  localparam int DCNT_W   = 5;
  localparam int NUM_W    = 19;
  localparam int LOT_W    = 9;
  localparam int DT_W     = 7;
  localparam int CIDX_W   = 3;

  // register indexes
  localparam logic [CIDX_W-1:0] REG_CAL_100 = 3'd0;
  localparam logic [CIDX_W-1:0] REG_CAL_200 = 3'd1;
  localparam logic [CIDX_W-1:0] REG_CAL_300 = 3'd2;
  localparam logic [CIDX_W-1:0] REG_CAL_420 = 3'd3;
  localparam logic [CIDX_W-1:0] REG_REJECT  = 3'd4;

  // register reset values
  localparam logic [SAMPLE_W-1:0] RST_CAL_100 = 12'd1000;
  localparam logic [SAMPLE_W-1:0] RST_CAL_200 = 12'd2000;
  localparam logic [SAMPLE_W-1:0] RST_CAL_300 = 12'd3000;
  localparam logic [SAMPLE_W-1:0] RST_CAL_420 = 12'd4000;
  localparam logic [SAMPLE_W-1:0] RST_REJECT  = 12'd4060;

  // segment end temperatures and spans
  localparam logic [LOT_W-1:0] TEMP_0   = 9'd0;
  localparam logic [LOT_W-1:0] TEMP_100 = 9'd100;
  localparam logic [LOT_W-1:0] TEMP_200 = 9'd200;
  localparam logic [LOT_W-1:0] TEMP_300 = 9'd300;
  localparam logic [DT_W-1:0]  SPAN_100 = 7'd100;
  localparam logic [DT_W-1:0]  SPAN_120 = 7'd120;

  localparam logic [TEMP_W-1:0] TEMP_MAX = 16'hFFFF;

  typedef struct packed {
    logic accept;     // take input word
    logic seg;        // pick calibration segment
    logic mul;        // offset times span
    logic div_start;  // kick the serial divider
    logic fix;        // sign, clamp, ambient
    logic sum;        // window update
    logic load;       // load output register
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_full;
  } status_t;

endpackage

FILE: src/tla_ram.sv
// ----------------------------------------------------------------------------
// tla_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module tla_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/tla_div.sv
// ----------------------------------------------------------------------------
// tla_div
// restoring bit-serial unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tla_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [tla_pkg::DIVD_W-1:0] dividend,
  input  logic [tla_pkg::DIVS_W-1:0] divisor,
  output logic [tla_pkg::DIVD_W-1:0] quotient,
  output logic                       busy
);

  logic [tla_pkg::DIVS_W-1:0] rem;
  logic [tla_pkg::DIVS_W-1:0] dvs;
  logic [tla_pkg::DCNT_W-1:0] cnt;
  logic [tla_pkg::DIVS_W:0]   shifted;
  logic                       fits;

  assign shifted = {rem, quotient[tla_pkg::DIVD_W-1]};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= tla_pkg::DCNT_W'(tla_pkg::DIVD_W);
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      busy <= cnt != tla_pkg::DCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? tla_pkg::DIVS_W'(shifted - {1'b0, dvs})
                       : shifted[tla_pkg::DIVS_W-1:0];
      quotient <= {quotient[tla_pkg::DIVD_W-2:0], fits};
    end
  end

endmodule

FILE: src/tla_datapath.sv
// ----------------------------------------------------------------------------
// tla_datapath
// calibration registers, segment math, window store and output register
// ----------------------------------------------------------------------------
module tla_datapath #(
  parameter int WINDOW_LEN = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tla_pkg::cmd_t                cmd,
  output tla_pkg::status_t             status,
  input  logic                         cfg_we,
  input  logic [tla_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [tla_pkg::SAMPLE_W-1:0] cfg_data,
  input  logic [tla_pkg::SAMPLE_W-1:0] adc_sample,
  input  logic [tla_pkg::AMB_W-1:0]    ambient_temp,
  input  logic                         out_stall,
  output logic                         out_valid,
  output logic [tla_pkg::TEMP_W-1:0]   tip_temp,
  output logic                         sample_rejected
);

  localparam int PTR_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

  // mean by reciprocal multiply; exact for sums under 2^22 and lengths up to 64
  localparam int MEAN_SH  = tla_pkg::SUM_W + 6;
  localparam int MEAN_P_W = tla_pkg::SUM_W + MEAN_SH + 1;
  localparam logic [MEAN_SH:0] MEAN_RECIP =
    (MEAN_SH+1)'(((64'd1 << MEAN_SH) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

  logic [tla_pkg::SAMPLE_W-1:0] cal_100, cal_200, cal_300, cal_420, reject_limit;
  logic [tla_pkg::SAMPLE_W-1:0] last_good;
  logic [tla_pkg::AMB_W-1:0]    ambient;
  logic                         rejected;

  // segment registers
  logic [tla_pkg::SAMPLE_W-1:0] diff;
  logic signed [tla_pkg::SAMPLE_W:0] den;
  logic [tla_pkg::LOT_W-1:0]    lo_temp;
  logic [tla_pkg::DT_W-1:0]     span;
  logic [tla_pkg::NUM_W-1:0]    num;
  logic [tla_pkg::SAMPLE_W-1:0] den_abs;
  logic                         den_neg;
  logic                         den_zero;
  logic [tla_pkg::TEMP_W-1:0]   temp;

  // window
  logic [tla_pkg::SUM_W-1:0]    win_sum;
  logic [PTR_W-1:0]             ptr;
  logic [WINDOW_LEN-1:0]        slot_valid;
  logic [tla_pkg::TEMP_W-1:0]   ram_rdata;
  logic [tla_pkg::TEMP_W-1:0]   oldest;
  logic [MEAN_P_W-1:0]          mean_prod;

  // divider
  logic [tla_pkg::DIVD_W-1:0]   div_dividend;
  logic [tla_pkg::DIVS_W-1:0]   div_divisor;
  logic [tla_pkg::DIVD_W-1:0]   div_quo;
  logic                         div_busy;

  // segment selection combinational
  logic [tla_pkg::SAMPLE_W-1:0] seg_lo, seg_hi;
  logic [tla_pkg::LOT_W-1:0]    seg_lo_temp;
  logic [tla_pkg::DT_W-1:0]     seg_span;

  // fixup combinational
  logic [tla_pkg::NUM_W-1:0]    q;
  logic [tla_pkg::NUM_W:0]      pos_val;
  logic [tla_pkg::TEMP_W-1:0]   seg_val;
  logic [tla_pkg::TEMP_W:0]     amb_val;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_100      <= tla_pkg::RST_CAL_100;
      cal_200      <= tla_pkg::RST_CAL_200;
      cal_300      <= tla_pkg::RST_CAL_300;
      cal_420      <= tla_pkg::RST_CAL_420;
      reject_limit <= tla_pkg::RST_REJECT;
    end else if (cfg_we) begin
      case (cfg_index)
        tla_pkg::REG_CAL_100: cal_100      <= cfg_data;
        tla_pkg::REG_CAL_200: cal_200      <= cfg_data;
        tla_pkg::REG_CAL_300: cal_300      <= cfg_data;
        tla_pkg::REG_CAL_420: cal_420      <= cfg_data;
        tla_pkg::REG_REJECT:  reject_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // glitch filter
  always_ff @(posedge clk) begin
    if (rst) begin
      last_good <= '0;
    end else if (cmd.accept && adc_sample < reject_limit) begin
      last_good <= adc_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ambient  <= ambient_temp;
      rejected <= adc_sample >= reject_limit;
    end
  end

  always_comb begin
    if (last_good < cal_100) begin
      seg_lo      = '0;
      seg_hi      = cal_100;
      seg_lo_temp = tla_pkg::TEMP_0;
      seg_span    = tla_pkg::SPAN_100;
    end else if (last_good < cal_200) begin
      seg_lo      = cal_100;
      seg_hi      = cal_200;
      seg_lo_temp = tla_pkg::TEMP_100;
      seg_span    = tla_pkg::SPAN_100;
    end else if (last_good < cal_300) begin
      seg_lo      = cal_200;
      seg_hi      = cal_300;
      seg_lo_temp = tla_pkg::TEMP_200;
      seg_span    = tla_pkg::SPAN_100;
    end else begin
      seg_lo      = cal_300;
      seg_hi      = cal_420;
      seg_lo_temp = tla_pkg::TEMP_300;
      seg_span    = tla_pkg::SPAN_120;
    end
  end

  // sample is never below the chosen lower code, so diff stays non-negative
  always_ff @(posedge clk) begin
    if (cmd.seg) begin
      diff    <= last_good - seg_lo;
      den     <= $signed({1'b0, seg_hi}) - $signed({1'b0, seg_lo});
      lo_temp <= seg_lo_temp;
      span    <= seg_span;
    end
    if (cmd.mul) begin
      num      <= tla_pkg::NUM_W'(diff) * tla_pkg::NUM_W'(span);
      den_neg  <= den[tla_pkg::SAMPLE_W];
      den_zero <= den == '0;
      den_abs  <= den[tla_pkg::SAMPLE_W] ? tla_pkg::SAMPLE_W'(-den)
                                         : den[tla_pkg::SAMPLE_W-1:0];
    end
  end

  assign div_dividend = num;
  assign div_divisor  = den_abs;

  tla_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .busy     (div_busy)
  );

  // quotient of the segment math fits the numerator width
  assign q       = div_quo[tla_pkg::NUM_W-1:0];
  assign pos_val = {1'b0, q} + (tla_pkg::NUM_W+1)'(lo_temp);

  always_comb begin
    if (den_zero) begin
      seg_val = tla_pkg::TEMP_W'(lo_temp);
    end else if (den_neg) begin
      seg_val = (q > tla_pkg::NUM_W'(lo_temp)) ? '0
              : tla_pkg::TEMP_W'(tla_pkg::NUM_W'(lo_temp) - q);
    end else begin
      seg_val = (pos_val > (tla_pkg::NUM_W+1)'(tla_pkg::TEMP_MAX)) ? tla_pkg::TEMP_MAX
              : pos_val[tla_pkg::TEMP_W-1:0];
    end
  end

  assign amb_val = {1'b0, seg_val} + (tla_pkg::TEMP_W+1)'(ambient);

  always_ff @(posedge clk) begin
    if (cmd.fix) begin
      temp <= amb_val[tla_pkg::TEMP_W] ? tla_pkg::TEMP_MAX : amb_val[tla_pkg::TEMP_W-1:0];
    end
  end

  // window store
  tla_ram #(
    .WIDTH (tla_pkg::TEMP_W),
    .DEPTH (WINDOW_LEN)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.sum),
    .waddr (ptr),
    .wdata (temp),
    .raddr (ptr),
    .rdata (ram_rdata)
  );

  assign oldest = slot_valid[ptr] ? ram_rdata : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_sum    <= '0;
      ptr        <= '0;
      slot_valid <= '0;
    end else if (cmd.sum) begin
      win_sum         <= win_sum - tla_pkg::SUM_W'(oldest) + tla_pkg::SUM_W'(temp);
      slot_valid[ptr] <= 1'b1;
      ptr             <= (ptr == PTR_W'(WINDOW_LEN - 1)) ? '0 : ptr + 1'b1;
    end
  end

  // window mean, truncated
  assign mean_prod = MEAN_P_W'(win_sum) * MEAN_P_W'(MEAN_RECIP);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tip_temp        <= tla_pkg::TEMP_W'(mean_prod >> MEAN_SH);
      sample_rejected <= rejected;
    end
  end

  assign status.div_busy = div_busy;
  assign status.out_full = out_valid;

endmodule

FILE: src/tla_ctrl.sv
// ----------------------------------------------------------------------------
// tla_ctrl
// sequencer for one word: segment, multiply, divide, fix, window, mean
// ----------------------------------------------------------------------------
module tla_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             out_stall,
  input  tla_pkg::status_t status,
  output tla_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SEG  = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_D1S  = 4'd3;
  localparam logic [3:0] S_D1W  = 4'd4;
  localparam logic [3:0] S_FIX  = 4'd5;
  localparam logic [3:0] S_SUM  = 4'd6;
  localparam logic [3:0] S_LOAD = 4'd7;

  logic [3:0] state, state_next;
  logic       out_free;

  assign out_free = !status.out_full || !out_stall;
  assign in_stall = state != S_IDLE;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    case (state)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) state_next = S_SEG;
      end
      S_SEG: begin
        cmd.seg    = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_D1S;
      end
      S_D1S: begin
        cmd.div_start = 1'b1;
        state_next    = S_D1W;
      end
      S_D1W: begin
        if (!status.div_busy) state_next = S_FIX;
      end
      S_FIX: begin
        cmd.fix    = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.load = out_free;
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_div_runs: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> status.div_busy)
    else $error("divider did not start");

  a_busy_in_wait: assert property (@(posedge clk) disable iff (rst)
    status.div_busy |-> (state == S_D1W))
    else $error("divider busy outside the wait state");

  a_load_fills: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> status.out_full)
    else $error("output register not filled after load");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (!status.out_full || !out_stall))
    else $error("load over a stalled word");
`endif

endmodule

FILE: src/thermocouple_linearize_average.sv
// ----------------------------------------------------------------------------
// thermocouple_linearize_average
// thermocouple adc linearizer with glitch reject and moving-average window
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in      | input     | in_valid / in_stall    | adc_sample, ambient_temp
//  out     | output    | out_valid / out_stall  | tip_temp, sample_rejected
//  cfg     | input     | cfg_we (no wait)       | cfg_index, cfg_data
//
//  one word at a time; a word reaches the output register after six sequencer
//  steps plus a wait on the 19-step bit-serial divider for the segment slope
//  the window mean is a reciprocal multiply done in the load step; with a free
//  output the next word can be taken in the cycle after the load
//  rst is synchronous; calibration registers return to their defaults and
//  the window, its sum and the last good sample clear at once
//  a stalled output word holds; one more input word is taken meanwhile and
//  waits in the load step until the output register frees
// ----------------------------------------------------------------------------
module thermocouple_linearize_average #(
  parameter int WINDOW_LEN = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  // input word
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tla_pkg::SAMPLE_W-1:0] adc_sample,
  input  logic [tla_pkg::AMB_W-1:0]    ambient_temp,
  // result word
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tla_pkg::TEMP_W-1:0]   tip_temp,
  output logic                         sample_rejected,
  // register writes
  input  logic                         cfg_we,
  input  logic [tla_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [tla_pkg::SAMPLE_W-1:0] cfg_data
);

  // command and status between sequencer and datapath
  tla_pkg::cmd_t    cmd;
  tla_pkg::status_t status;

  // sequencer: steps one word through its phases
  tla_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: calibration math, window ram, divider, output register
  tla_datapath #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .adc_sample      (adc_sample),
    .ambient_temp    (ambient_temp),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .tip_temp        (tip_temp),
    .sample_rejected (sample_rejected)
  );

endmodule

FILE: tb/tb_thermocouple_linearize_average.sv
// ----------------------------------------------------------------------------
// tb_thermocouple_linearize_average
// self-checking bench for the thermocouple linearizer and moving average
// ----------------------------------------------------------------------------
//  a table of directed words and register writes runs first: reset values,
//  field extremes, segment edges, glitch reject, saturation, negative slope,
//  zero-width segment and ignored register indexes. random phases follow,
//  each with its own calibration and its own mix of sender gaps and
//  receiver stalls; two of them hold the output off long enough to back
//  the block up. every result word is checked against a pinned value or a local model
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_thermocouple_linearize_average;

  localparam int WIN         = 8;
  localparam int LATENCY     = 26;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES      = 14;
  localparam int PHASE_WORDS = 100;

  // segment end temperatures, degrees above ambient
  localparam longint DEG_0   = 0;
  localparam longint DEG_100 = 100;
  localparam longint DEG_200 = 200;
  localparam longint DEG_300 = 300;
  localparam longint DEG_420 = 420;

  // register indexes the block does not decode
  localparam logic [tla_pkg::CIDX_W-1:0] REG_SPARE_LO  = 3'd5;
  localparam logic [tla_pkg::CIDX_W-1:0] REG_SPARE_MID = 3'd6;
  localparam logic [tla_pkg::CIDX_W-1:0] REG_SPARE_HI  = 3'd7;

  typedef struct packed {
    logic [tla_pkg::TEMP_W-1:0] tip;
    logic                       rej;
  } tip_word_t;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    int unsigned a;     // adc sample, or register index
    int unsigned b;     // ambient, or register data
    bit          pinned;
    int unsigned tip;
    bit          rej;
  } dir_row_t;

  typedef enum {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_t;
  typedef enum {CAL_DEFAULT, CAL_ORDERED, CAL_ANY, CAL_STEEP, CAL_FLOOR, CAL_CEIL}
    cal_kind_t;

  // dut ports
  logic                         clk;
  logic                         rst          = 1'b1;
  logic                         in_valid     = 1'b0;
  logic                         in_stall;
  logic [tla_pkg::SAMPLE_W-1:0] adc_sample   = '0;
  logic [tla_pkg::AMB_W-1:0]    ambient_temp = '0;
  logic                         out_valid;
  logic                         out_stall    = 1'b0;
  logic [tla_pkg::TEMP_W-1:0]   tip_temp;
  logic                         sample_rejected;
  logic                         cfg_we       = 1'b0;
  logic [tla_pkg::CIDX_W-1:0]   cfg_index    = '0;
  logic [tla_pkg::SAMPLE_W-1:0] cfg_data     = '0;

  thermocouple_linearize_average #(.WINDOW_LEN(WIN)) u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .adc_sample      (adc_sample),
    .ambient_temp    (ambient_temp),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .tip_temp        (tip_temp),
    .sample_rejected (sample_rejected),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // local copy of the calibration and the averaging state
  logic [tla_pkg::SAMPLE_W-1:0] m_cal100, m_cal200, m_cal300, m_cal420, m_reject;
  logic [tla_pkg::SAMPLE_W-1:0] m_good;
  logic [tla_pkg::TEMP_W-1:0]   m_win [WIN];
  logic [tla_pkg::SUM_W-1:0]    m_sum;
  int unsigned                  m_ptr;

  tip_word_t tip_expect_q [$];

  // idle mix, percent per cycle
  int unsigned src_pct = 0;
  int unsigned snk_pct = 0;

  // long hold-off requests: main side bumps asked, receiver side serves
  int unsigned hold_asked  = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left   = 0;

  int unsigned n_errors = 0;
  int unsigned n_words  = 0;
  int unsigned n_seen   = 0;
  int unsigned n_rej    = 0;
  int unsigned n_sat    = 0;
  int unsigned n_cfg    = 0;
  int unsigned tip_lo   = 32'hFFFF_FFFF;
  int unsigned tip_hi   = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #4_000_000;
    $display("timeout: %0d words still expected", tip_expect_q.size());
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------- model

  function automatic longint seg_value(longint s, longint lo_code, longint hi_code,
                                       longint lo_deg, longint hi_deg);
    longint den;
    den = hi_code - lo_code;
    // zero-width segment sits at its lower temperature
    if (den == 0) return lo_deg;
    // signed division truncates toward zero
    return lo_deg + ((s - lo_code) * (hi_deg - lo_deg)) / den;
  endfunction

  function automatic longint linearize_code(logic [tla_pkg::SAMPLE_W-1:0] s);
    longint v;
    if (s < m_cal100)      v = seg_value(s, 0, m_cal100, DEG_0, DEG_100);
    else if (s < m_cal200) v = seg_value(s, m_cal100, m_cal200, DEG_100, DEG_200);
    else if (s < m_cal300) v = seg_value(s, m_cal200, m_cal300, DEG_200, DEG_300);
    else                   v = seg_value(s, m_cal300, m_cal420, DEG_300, DEG_420);
    // misordered codes can go negative, steep ones run past 16 bits
    if (v < 0) v = 0;
    if (v > tla_pkg::TEMP_MAX) v = tla_pkg::TEMP_MAX;
    return v;
  endfunction

  function automatic tip_word_t predict_tip_word(logic [tla_pkg::SAMPLE_W-1:0] s,
                                                 logic [tla_pkg::AMB_W-1:0] amb);
    tip_word_t   w;
    longint      t;
    int unsigned slot;
    w.rej = (s >= m_reject);
    // a glitch reuses the last good sample
    if (!w.rej) m_good = s;
    t = linearize_code(m_good) + amb;
    if (t > tla_pkg::TEMP_MAX) t = tla_pkg::TEMP_MAX;
    slot = (m_ptr >= WIN) ? 0 : m_ptr;
    m_sum = m_sum - m_win[slot] + t[tla_pkg::TEMP_W-1:0];
    m_win[slot] = t[tla_pkg::TEMP_W-1:0];
    m_ptr = (slot + 1 >= WIN) ? 0 : slot + 1;
    w.tip = tla_pkg::TEMP_W'(m_sum / WIN);
    return w;
  endfunction

  // ---------------------------------------------------------------- driving

  task automatic write_reg(input logic [tla_pkg::CIDX_W-1:0] idx,
                           input logic [tla_pkg::SAMPLE_W-1:0] d);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    case (idx)
      tla_pkg::REG_CAL_100: m_cal100 = d;
      tla_pkg::REG_CAL_200: m_cal200 = d;
      tla_pkg::REG_CAL_300: m_cal300 = d;
      tla_pkg::REG_CAL_420: m_cal420 = d;
      tla_pkg::REG_REJECT:  m_reject = d;
      default: ;  // undecoded index, no effect
    endcase
    n_cfg++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // offer one word; returns at the edge that takes it
  task automatic drive_word(input logic [tla_pkg::SAMPLE_W-1:0] s,
                            input logic [tla_pkg::AMB_W-1:0] amb,
                            input bit pinned, input tip_word_t pin_val);
    tip_word_t w;
    @(negedge clk);
    while (src_pct != 0 && $urandom_range(99) < src_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    adc_sample   <= s;
    ambient_temp <= amb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    w = predict_tip_word(s, amb);
    tip_expect_q.push_back(pinned ? pin_val : w);
    n_words++;
  endtask

  // drop valid and let every expected word come back
  task automatic drain_words();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tip_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin src_pct = 0;  snk_pct = 0;  end
      IDLE_SRC:  begin src_pct = 83; snk_pct = 0;  end
      IDLE_SNK:  begin src_pct = 0;  snk_pct = 83; end
      default:   begin src_pct = 16; snk_pct = 16; end
    endcase
  endtask

  task automatic load_calibration(input cal_kind_t kind);
    int          c [4];
    int unsigned r;
    logic [tla_pkg::SAMPLE_W-1:0] rj;
    case (kind)
      CAL_DEFAULT: c = '{tla_pkg::RST_CAL_100, tla_pkg::RST_CAL_200,
                         tla_pkg::RST_CAL_300, tla_pkg::RST_CAL_420};
      CAL_ORDERED: begin
        c[0] = $urandom_range(1500);
        for (int i = 1; i < 4; i++) c[i] = c[i-1] + $urandom_range(900);
        for (int i = 0; i < 4; i++) if (c[i] > 4095) c[i] = 4095;
      end
      CAL_ANY: for (int i = 0; i < 4; i++) c[i] = $urandom_range(4095);
      CAL_STEEP: begin
        // nearly everything extrapolates off the last segment
        c[0] = 0;
        c[1] = 0;
        c[2] = $urandom_range(100);
        c[3] = c[2] + $urandom_range(1, 3);
      end
      CAL_FLOOR: c = '{0, 0, 0, 0};
      default:   c = '{4095, 4095, 4095, 4095};
    endcase
    r = $urandom_range(9);
    if (kind == CAL_DEFAULT) rj = tla_pkg::RST_REJECT;
    else if (r == 0)         rj = '0;
    else if (r == 1)         rj = '1;
    else                     rj = tla_pkg::SAMPLE_W'($urandom_range(2048, 4095));
    write_reg(tla_pkg::REG_CAL_100, tla_pkg::SAMPLE_W'(c[0]));
    write_reg(tla_pkg::REG_CAL_200, tla_pkg::SAMPLE_W'(c[1]));
    write_reg(tla_pkg::REG_CAL_300, tla_pkg::SAMPLE_W'(c[2]));
    write_reg(tla_pkg::REG_CAL_420, tla_pkg::SAMPLE_W'(c[3]));
    write_reg(tla_pkg::REG_REJECT, rj);
    if ($urandom_range(1))
      write_reg(tla_pkg::CIDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                tla_pkg::SAMPLE_W'($urandom()));
  endtask

  // samples lean toward the ends, the calibration codes and the reject edge
  function automatic logic [tla_pkg::SAMPLE_W-1:0] pick_sample();
    int unsigned r;
    int          c;
    r = $urandom_range(99);
    if (r < 8) return $urandom_range(1) ? '1 : '0;
    if (r < 30) begin
      case ($urandom_range(4))
        0: c = m_cal100;
        1: c = m_cal200;
        2: c = m_cal300;
        3: c = m_cal420;
        default: c = m_reject;
      endcase
      c = c + int'($urandom_range(4)) - 2;
      if (c < 0) c = 0;
      if (c > 4095) c = 4095;
      return tla_pkg::SAMPLE_W'(c);
    end
    return tla_pkg::SAMPLE_W'($urandom_range(4095));
  endfunction

  function automatic logic [tla_pkg::AMB_W-1:0] pick_ambient();
    if ($urandom_range(99) < 12) return $urandom_range(1) ? '1 : '0;
    return tla_pkg::AMB_W'($urandom_range(255));
  endfunction

  // ---------------------------------------------------------------- receiver

  // random stalls, plus a long counted hold-off on request
  always @(negedge clk) begin
    if (hold_served != hold_asked) begin
      hold_served <= hold_asked;
      hold_left   <= HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (snk_pct != 0) && ($urandom_range(99) < snk_pct);
    end
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    n_errors++;
    if (n_errors <= 30)
      $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
  endtask

  always @(posedge clk) begin : check_out
    tip_word_t want;
    if (!rst && out_valid && !out_stall) begin
      n_seen++;
      if (sample_rejected) n_rej++;
      if (tip_temp == tla_pkg::TEMP_MAX) n_sat++;
      if (tip_temp < tip_lo) tip_lo = tip_temp;
      if (tip_temp > tip_hi) tip_hi = tip_temp;
      if (tip_expect_q.size() == 0) begin
        report_mismatch("unexpected word, tip_temp", tip_temp, 0);
      end else begin
        want = tip_expect_q.pop_front();
        if (tip_temp !== want.tip)
          report_mismatch("tip_temp", tip_temp, want.tip);
        if (sample_rejected !== want.rej)
          report_mismatch("sample_rejected", sample_rejected, want.rej);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    dir_row_t  dir_tab [$];
    tip_word_t pin;

    m_cal100 = tla_pkg::RST_CAL_100;
    m_cal200 = tla_pkg::RST_CAL_200;
    m_cal300 = tla_pkg::RST_CAL_300;
    m_cal420 = tla_pkg::RST_CAL_420;
    m_reject = tla_pkg::RST_REJECT;
    m_good   = '0;
    m_sum    = '0;
    m_ptr    = 0;
    for (int i = 0; i < WIN; i++) m_win[i] = '0;

    dir_tab = '{
      // reset calibration, empty window
      '{ROW_WORD, 0,    0,   1, 0,  0},  // all zero in, all zero out
      '{ROW_WORD, 4095, 255, 1, 31, 1},  // glitch reuses zero, mean of 255
      '{ROW_WORD, 4059, 0,   1, 85, 0},  // just under reject, 427 into window
      '{ROW_WORD, 999,  128, 0, 0,  0},  // top of first segment
      '{ROW_WORD, 1000, 1,   0, 0,  0},  // second segment starts
      '{ROW_WORD, 2000, 2,   0, 0,  0},
      '{ROW_WORD, 3000, 64,  0, 0,  0},  // last segment starts
      '{ROW_WORD, 4060, 0,   0, 0,  0},  // exactly at the reject limit
      '{ROW_WORD, 2730, 170, 0, 0,  0},  // alternating bits
      '{ROW_WORD, 1365, 85,  0, 0,  0},
      // steep last segment, high codes extrapolate past 16 bits
      '{ROW_REG,  tla_pkg::REG_CAL_100, 0,    0, 0, 0},
      '{ROW_REG,  tla_pkg::REG_CAL_200, 0,    0, 0, 0},
      '{ROW_REG,  tla_pkg::REG_CAL_300, 0,    0, 0, 0},
      '{ROW_REG,  tla_pkg::REG_CAL_420, 1,    0, 0, 0},
      '{ROW_REG,  tla_pkg::REG_REJECT,  4095, 0, 0, 0},
      '{ROW_WORD, 4094, 255, 0, 0,  0},  // clamp, then ambient saturates
      '{ROW_WORD, 4094, 255, 0, 0,  0},
      // falling last segment
      '{ROW_REG,  tla_pkg::REG_CAL_300, 1000, 0, 0, 0},
      '{ROW_REG,  tla_pkg::REG_CAL_420, 999,  0, 0, 0},
      '{ROW_WORD, 4094, 0,   0, 0,  0},  // clamps at zero
      '{ROW_WORD, 1001, 17,  0, 0,  0},
      // zero-width last segment
      '{ROW_REG,  tla_pkg::REG_CAL_420, 1000, 0, 0, 0},
      '{ROW_WORD, 2500, 7,   0, 0,  0},
      // every sample is a glitch
      '{ROW_REG,  tla_pkg::REG_REJECT,  0,    0, 0, 0},
      '{ROW_WORD, 123,  9,   0, 0,  0},
      '{ROW_WORD, 0,    0,   0, 0,  0},
      // undecoded indexes must not touch anything
      '{ROW_REG,  REG_SPARE_LO,  4095, 0, 0, 0},
      '{ROW_REG,  REG_SPARE_MID, 4095, 0, 0, 0},
      '{ROW_REG,  REG_SPARE_HI,  4095, 0, 0, 0},
      // all codes at the top, first segment spans everything
      '{ROW_REG,  tla_pkg::REG_CAL_100, 4095, 0, 0, 0},
      '{ROW_REG,  tla_pkg::REG_CAL_200, 4095, 0, 0, 0},
      '{ROW_REG,  tla_pkg::REG_CAL_300, 4095, 0, 0, 0},
      '{ROW_REG,  tla_pkg::REG_CAL_420, 4095, 0, 0, 0},
      '{ROW_REG,  tla_pkg::REG_REJECT,  4095, 0, 0, 0},
      '{ROW_WORD, 4094, 200, 0, 0,  0},
      '{ROW_WORD, 4095, 3,   0, 0,  0},  // glitch at the top limit
      '{ROW_WORD, 0,    255, 0, 0,  0}
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_idle(IDLE_NONE);
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_REG) begin
        drain_words();
        write_reg(tla_pkg::CIDX_W'(dir_tab[i].a), tla_pkg::SAMPLE_W'(dir_tab[i].b));
      end else begin
        pin.tip = tla_pkg::TEMP_W'(dir_tab[i].tip);
        pin.rej = dir_tab[i].rej;
        drive_word(tla_pkg::SAMPLE_W'(dir_tab[i].a), tla_pkg::AMB_W'(dir_tab[i].b),
                   dir_tab[i].pinned, pin);
      end
    end

    // random phases: first six cover each calibration style once
    for (int p = 0; p < PHASES; p++) begin
      drain_words();
      set_idle(idle_mode_t'(p % 4));
      load_calibration(p < 6 ? cal_kind_t'(p) : cal_kind_t'($urandom_range(5)));
      for (int i = 0; i < PHASE_WORDS; i++) begin
        drive_word(pick_sample(), pick_ambient(), 1'b0, '0);
        // back the block up while the sender keeps offering
        if ((p == 4 || p == 8) && i == PHASE_WORDS / 2) hold_asked++;
      end
    end

    drain_words();
    repeat (2 * LATENCY + 10) @(posedge clk);

    $display("sent %0d words over %0d register writes, %0d long hold-offs;",
             n_words, n_cfg, hold_asked);
    $display("checked %0d results: %0d glitches, tip %0d..%0d, %0d saturated means",
             n_seen, n_rej, tip_lo, tip_hi, n_sat);
    if (n_errors == 0 && tip_expect_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d words never came", n_errors, tip_expect_q.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
